### design/bpcb_pkg.sv
`default_nettype none

package bpcb_pkg;

    localparam int PIX_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SFMT_W    = 3;
    localparam int DFMT_W    = 2;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_FORMAT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR    = 3'd4;

    // Source formats
    localparam logic [SFMT_W-1:0] SFMT_MONO     = 3'd0;
    localparam logic [SFMT_W-1:0] SFMT_RGBA8888 = 3'd1;
    localparam logic [SFMT_W-1:0] SFMT_BGRA8888 = 3'd2;
    localparam logic [SFMT_W-1:0] SFMT_RGB888   = 3'd3;
    localparam logic [SFMT_W-1:0] SFMT_BGR888   = 3'd4;

    // Destination format bits: bit 0 swaps red/blue, bit 1 is a three-byte format
    localparam int DFMT_SWAP_BIT  = 0;
    localparam int DFMT_THREE_BIT = 1;

    // Reset values
    localparam logic              RST_BLEND_MODE    = 1'b0;
    localparam logic [SFMT_W-1:0] RST_SOURCE_FORMAT = SFMT_RGBA8888;
    localparam logic [DFMT_W-1:0] RST_DEST_FORMAT   = 2'd0;
    localparam logic [PIX_W-1:0]  RST_FORE_COLOR    = 32'hffff_ffff;
    localparam logic [PIX_W-1:0]  RST_BACK_COLOR    = 32'hff00_0000;

    typedef logic [PIX_W-1:0]     pixel_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef struct packed {
        logic              blend_mode;
        logic [SFMT_W-1:0] source_format;
        logic [DFMT_W-1:0] dest_format;
        pixel_t            fore_color;
        pixel_t            back_color;
    } cfg_t;

endpackage

`default_nettype wire

### design/bpcb_in_if.sv
`default_nettype none

interface bpcb_in_if;
    import bpcb_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t source_pixel;
    pixel_t dest_pixel;

    modport source (output valid, output source_pixel, output dest_pixel, input ready);
    modport sink   (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

`default_nettype wire

### design/bpcb_out_if.sv
`default_nettype none

interface bpcb_out_if;
    import bpcb_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t out_pixel;
    logic   write_enable;

    modport source (output valid, output out_pixel, output write_enable, input ready);
    modport sink   (input valid, input out_pixel, input write_enable, output ready);
endinterface

`default_nettype wire

### design/bpcb_cfg_if.sv
`default_nettype none

interface bpcb_cfg_if;
    import bpcb_pkg::*;

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    pixel_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/bpcb_cfg_regs.sv
`default_nettype none

module bpcb_cfg_regs (
    input  wire logic      clk,
    input  wire logic      rst_n,
    bpcb_cfg_if.sink       cfg,
    output bpcb_pkg::cfg_t cfg_q
);
    import bpcb_pkg::*;

    cfg_t cfg_reg;
    logic wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_mode    <= RST_BLEND_MODE;
            cfg_reg.source_format <= RST_SOURCE_FORMAT;
            cfg_reg.dest_format   <= RST_DEST_FORMAT;
            cfg_reg.fore_color    <= RST_FORE_COLOR;
            cfg_reg.back_color    <= RST_BACK_COLOR;
        end
        else if (wr)
        begin
            case (cfg.index)
                REG_BLEND_MODE:    cfg_reg.blend_mode    <= cfg.data[0];
                REG_SOURCE_FORMAT: cfg_reg.source_format <= cfg.data[SFMT_W-1:0];
                REG_DEST_FORMAT:   cfg_reg.dest_format   <= cfg.data[DFMT_W-1:0];
                REG_FORE_COLOR:    cfg_reg.fore_color    <= cfg.data;
                REG_BACK_COLOR:    cfg_reg.back_color    <= cfg.data;
                default:           ;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/bpcb_datapath.sv
`default_nettype none

module bpcb_datapath (
    input  wire bpcb_pkg::cfg_t   cfg_q,
    input  wire bpcb_pkg::pixel_t source_pixel,
    input  wire bpcb_pkg::pixel_t dest_pixel,
    output bpcb_pkg::pixel_t      out_pixel,
    output logic                  write_enable
);
    import bpcb_pkg::*;

    // floor(x / 255), exact for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + 16'd1 + {8'd0, x[15:8]};
        return t[15:8];
    endfunction

    logic       src_ok;
    pixel_t     mono_c;
    logic [7:0] s_r, s_g, s_b, s_a;
    logic [7:0] d_r, d_g, d_b;
    logic [7:0] inv_a;
    logic [7:0] r_r, r_g, r_b;
    logic [7:0] o_r, o_g, o_b;
    logic       swap, three, blend_mix;
    logic       alpha_zero, alpha_full;

    assign mono_c = source_pixel[0] ? cfg_q.fore_color : cfg_q.back_color;

    always_comb
    begin
        src_ok = 1'b1;
        s_r    = source_pixel[7:0];
        s_g    = source_pixel[15:8];
        s_b    = source_pixel[23:16];
        s_a    = source_pixel[31:24];
        case (cfg_q.source_format)
            SFMT_MONO:
            begin
                s_r = mono_c[7:0];
                s_g = mono_c[15:8];
                s_b = mono_c[23:16];
                s_a = mono_c[31:24];
            end
            SFMT_RGBA8888: ;
            SFMT_BGRA8888:
            begin
                s_r = source_pixel[23:16];
                s_b = source_pixel[7:0];
            end
            SFMT_RGB888:
                s_a = 8'hff;
            SFMT_BGR888:
            begin
                s_r = source_pixel[23:16];
                s_b = source_pixel[7:0];
                s_a = 8'hff;
            end
            default:
                src_ok = 1'b0;
        endcase
    end

    assign swap  = cfg_q.dest_format[DFMT_SWAP_BIT];
    assign three = cfg_q.dest_format[DFMT_THREE_BIT];

    assign d_r = swap ? dest_pixel[23:16] : dest_pixel[7:0];
    assign d_g = dest_pixel[15:8];
    assign d_b = swap ? dest_pixel[7:0] : dest_pixel[23:16];

    assign inv_a = 8'hff - s_a;
    assign r_r   = div255(16'(s_r * s_a) + 16'(d_r * inv_a));
    assign r_g   = div255(16'(s_g * s_a) + 16'(d_g * inv_a));
    assign r_b   = div255(16'(s_b * s_a) + 16'(d_b * inv_a));

    assign alpha_zero = (s_a == 8'h00);
    assign alpha_full = (s_a == 8'hff);
    assign blend_mix  = cfg_q.blend_mode && !alpha_full;

    assign o_r = blend_mix ? r_r : s_r;
    assign o_g = blend_mix ? r_g : s_g;
    assign o_b = blend_mix ? r_b : s_b;

    always_comb
    begin
        write_enable = src_ok && !(cfg_q.blend_mode && alpha_zero);
        if (write_enable)
            out_pixel = {(three ? 8'h00 : s_a), (swap ? o_r : o_b), o_g, (swap ? o_b : o_r)};
        else
            out_pixel = '0;
    end

endmodule

`default_nettype wire

### design/blit_pixel_convert_blend_unit.sv
// Blitter pixel datapath: format conversion and alpha blending.
// Channels:
//   pix_in  - request carries source_pixel and dest_pixel (valid/ready).
//   pix_out - result carries out_pixel and write_enable (valid/ready);
//             write_enable low means leave the destination pixel untouched.
//   cfg     - register writes (index, data); always ready, takes effect on
//             the next cycle. Write only while no pixel is in flight.
// Path: an accepted request goes through the input register, one pass of
// convert/blend logic and the result register. Throughput: one pixel per
// clock while pix_out is not stalled, set by the two-stage register
// pipeline; the per-channel 8x8 multiply and divide-by-255 sit in that pass.
// Reset: both stages empty, registers return to RGBA8888 source, RGBA8888
// destination, replace mode, white foreground, opaque black background.
// Stall: when pix_out.ready is low the result register holds; the input
// register still fills, and pix_in.ready drops only when both are full.
`default_nettype none

module blit_pixel_convert_blend_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bpcb_in_if.sink     pix_in,
    bpcb_out_if.source  pix_out,
    bpcb_cfg_if.sink    cfg
);
    import bpcb_pkg::*;

    cfg_t   cfg_q;

    logic   s1_valid_reg, s1_valid_next;
    pixel_t s1_src_reg;
    pixel_t s1_dst_reg;

    logic   out_valid_reg, out_valid_next;
    pixel_t out_pixel_reg;
    logic   out_we_reg;

    pixel_t dp_pixel;
    logic   dp_we;

    logic   in_acc;
    logic   s2_free;
    logic   s2_load;

    bpcb_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    bpcb_datapath u_dp (
        .cfg_q        (cfg_q),
        .source_pixel (s1_src_reg),
        .dest_pixel   (s1_dst_reg),
        .out_pixel    (dp_pixel),
        .write_enable (dp_we)
    );

    assign s2_free      = !out_valid_reg || pix_out.ready;
    assign s2_load      = s1_valid_reg && s2_free;
    assign pix_in.ready = !s1_valid_reg || s2_free;
    assign in_acc       = pix_in.valid && pix_in.ready;

    assign s1_valid_next  = in_acc || (s1_valid_reg && !s2_free);
    assign out_valid_next = s2_free ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_src_reg <= pix_in.source_pixel;
            s1_dst_reg <= pix_in.dest_pixel;
        end
        if (s2_load)
        begin
            out_pixel_reg <= dp_pixel;
            out_we_reg    <= dp_we;
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.out_pixel    = out_pixel_reg;
    assign pix_out.write_enable = out_we_reg;

`ifndef SYNTHESIS
    // an accepted request always lands in the input stage
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted pixel not held in input stage");

    // a pixel in the input stage is never dropped while the output is stalled
    a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_free |=> s1_valid_reg && $stable(s1_src_reg))
        else $error("input stage lost a pixel under stall");

    // an unwritten result carries a zero pixel
    a_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_we_reg |-> out_pixel_reg == '0)
        else $error("skipped pixel has nonzero data");

    // output drains when nothing waits behind it
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pix_out.ready && !s1_valid_reg |=> !out_valid_reg)
        else $error("result repeated after being taken");
`endif

endmodule

`default_nettype wire
